// ===== hw/rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, format codes and fixed-point coefficients of the pixel
// format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  // Operation codes
  localparam logic OP_CONVERT   = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  // Register indexes
  localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] CFG_DEST_FORMAT   = 2'd1;

  // Source formats
  localparam logic [1:0] SRC_GRAY = 2'd0;
  localparam logic [1:0] SRC_YUV  = 2'd1;
  localparam logic [1:0] SRC_RGB  = 2'd2;
  localparam logic [1:0] SRC_PAL  = 2'd3;

  // Destination formats
  localparam logic [2:0] DST_GRAY   = 3'd0;
  localparam logic [2:0] DST_YUV    = 3'd1;
  localparam logic [2:0] DST_RGB    = 3'd2;
  localparam logic [2:0] DST_BGRX   = 3'd3;
  localparam logic [2:0] DST_RGB565 = 3'd4;
  localparam logic [2:0] DST_RGB555 = 3'd5;

  localparam logic [1:0] SRC_RESET = SRC_RGB;
  localparam logic [2:0] DST_RESET = DST_YUV;

  // Fixed point: 14 fractional bits, products fit in 25 signed bits
  localparam int PROD_W    = 25;
  localparam int FIX_SHIFT = 14;
  localparam int SHR_W     = PROD_W - FIX_SHIFT;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SHR_W-1:0]  shr_t;

  localparam prod_t FIX_HALF = 25'sd8192;
  localparam prod_t K_ONE    = 25'sd16384;

  // RGB to YUV
  localparam prod_t K_YR =  25'sd4898;
  localparam prod_t K_YG =  25'sd9617;
  localparam prod_t K_YB =  25'sd1867;
  localparam prod_t K_UR = -25'sd2764;
  localparam prod_t K_UG = -25'sd5427;
  localparam prod_t K_UB =  25'sd8192;
  localparam prod_t K_VR = -25'sd8192;
  localparam prod_t K_VG =  25'sd6859;
  localparam prod_t K_VB =  25'sd1332;

  // YUV to RGB
  localparam prod_t K_RV = -25'sd22970;
  localparam prod_t K_GU = -25'sd5638;
  localparam prod_t K_GV =  25'sd11700;
  localparam prod_t K_BU =  25'sd29032;

  localparam logic signed [8:0] CHROMA_OFS9  = 9'sd127;
  localparam shr_t              CHROMA_OFS11 = 11'sd127;

  // Three bytes of one pixel, in input order
  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } pix_t;

  // Palette write request
  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    pix_t       rgb;
  } pal_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfc_palette.sv =====
// ----------------------------------------------------------------------------
// pfc_palette
// Palette RAM: one write port, one read port with registered read data.
// Out-of-range reads return black, out-of-range writes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_palette #(
  parameter int PALETTE_ENTRIES = pfc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [7:0]      rd_addr,
  input  pfc_pkg::pal_wr_t wr,
  output pfc_pkg::pix_t   rd_rgb
);
  import pfc_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  pix_t       mem [PALETTE_ENTRIES];
  pix_t       rd_q_r;
  logic       oob_r;
  logic       wr_ok;
  logic       rd_ok;

  assign wr_ok = {1'b0, wr.idx} < 9'(PALETTE_ENTRIES);
  assign rd_ok = {1'b0, rd_addr} < 9'(PALETTE_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr.en && wr_ok) begin
      mem[wr.idx[AW-1:0]] <= wr.rgb;
    end
  end

  // hold read data while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr[AW-1:0]];
      oob_r  <= !rd_ok;
    end
  end

  assign rd_rgb = oob_r ? '0 : rd_q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pfc_math.sv =====
// ----------------------------------------------------------------------------
// pfc_math
// Colour-space arithmetic: registered constant products, then add, round,
// floor shift and saturate (RGB results; chroma wraps). RGB to YUV and YUV to RGB run side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_math (
  input  logic          clk,
  input  logic          en,
  input  pfc_pkg::pix_t col,
  output pfc_pkg::pix_t yuv,
  output pfc_pkg::pix_t rgb
);
  import pfc_pkg::*;

  function automatic prod_t mulc(input logic signed [8:0] a, input prod_t k);
    prod_t ax;
    ax = prod_t'(a);
    return ax * k;
  endfunction

  // floor division by 2^14 is the upper slice of the sum
  function automatic shr_t shr(input prod_t s);
    return s[PROD_W-1:FIX_SHIFT];
  endfunction

  function automatic logic [7:0] sat8(input shr_t x);
    logic [7:0] q;
    if (x < 0) begin
      q = 8'd0;
    end else if (x > 11'sd255) begin
      q = 8'd255;
    end else begin
      q = x[7:0];
    end
    return q;
  endfunction

  logic signed [8:0] a0, a1, a2, u_s, v_s;

  assign a0  = $signed({1'b0, col.c0});
  assign a1  = $signed({1'b0, col.c1});
  assign a2  = $signed({1'b0, col.c2});
  assign u_s = a1 - CHROMA_OFS9;
  assign v_s = a2 - CHROMA_OFS9;

  prod_t yr_r, yg_r, yb_r, ur_r, ug_r, ub_r, vr_r, vg_r, vb_r;
  prod_t ry_r, rv_r, gu_r, gv_r, bu_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yr_r <= mulc(a0, K_YR);
      yg_r <= mulc(a1, K_YG);
      yb_r <= mulc(a2, K_YB);
      ur_r <= mulc(a0, K_UR);
      ug_r <= mulc(a1, K_UG);
      ub_r <= mulc(a2, K_UB);
      vr_r <= mulc(a0, K_VR);
      vg_r <= mulc(a1, K_VG);
      vb_r <= mulc(a2, K_VB);
      ry_r <= mulc(a0, K_ONE);
      rv_r <= mulc(v_s, K_RV);
      gu_r <= mulc(u_s, K_GU);
      gv_r <= mulc(v_s, K_GV);
      bu_r <= mulc(u_s, K_BU);
    end
  end

  prod_t y_sum, u_sum, v_sum, r_sum, g_sum, b_sum;
  shr_t  y_q, u_q, v_q;

  always_comb begin
    y_sum = yr_r + yg_r + yb_r + FIX_HALF;
    u_sum = ur_r + ug_r + ub_r + FIX_HALF;
    v_sum = vr_r + vg_r + vb_r + FIX_HALF;
    r_sum = ry_r + rv_r + FIX_HALF;
    g_sum = ry_r + gu_r + gv_r + FIX_HALF;
    b_sum = ry_r + bu_r + FIX_HALF;

    // luma always lands in 0..255
    y_q = shr(y_sum);
    // chroma wraps to eight bits after the offset
    u_q = shr(u_sum) + CHROMA_OFS11;
    v_q = shr(v_sum) + CHROMA_OFS11;

    yuv.c0 = y_q[7:0];
    yuv.c1 = u_q[7:0];
    yuv.c2 = v_q[7:0];

    rgb.c0 = sat8(shr(r_sum));
    rgb.c1 = sat8(shr(g_sum));
    rgb.c2 = sat8(shr(b_sum));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// pixel_format_converter
// One pixel per transfer between gray, YUV, RGB and palette sources and
// gray, YUV, RGB, BGRX, RGB565 and RGB555 destinations, with a palette RAM.
// ----------------------------------------------------------------------------
//   Channel | Handshake         | Carries
//   in_     | in_valid/in_stall | operation, three bytes, entry index, last
//   out_    | out_valid/stall   | four bytes, byte count, unsupported, last
//   cfg_    | cfg_valid/ready   | register index and data, always ready
//
// One transfer per cycle in and out while out_stall does not freeze the pipeline; a conversion
// passes through the palette RAM read, product register and output register stages.
// A palette write yields no result.
// Reset clears pipeline valids and sets the format registers to RGB source and
// YUV destination; the palette is undefined until written and needs no clearing pass.
// out_stall with a result waiting freezes the whole pipeline and raises
// in_stall in the same cycle; with no result waiting it has no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_converter #(
  parameter int PALETTE_ENTRIES = pfc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_entry_index,
  input  logic       in_last_pixel,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3,
  output logic [2:0] out_byte_count,
  output logic       out_unsupported,
  output logic       out_last_out,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);
  import pfc_pkg::*;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       uns;
  } res_t;

  function automatic res_t put_rgb(input logic [2:0] dst, input pix_t c);
    res_t       q;
    logic [15:0] w;
    q = '0;
    w = '0;
    unique case (dst)
      DST_RGB: begin
        q.b0 = c.c0; q.b1 = c.c1; q.b2 = c.c2; q.cnt = 3'd3;
      end
      DST_BGRX: begin
        q.b0 = c.c2; q.b1 = c.c1; q.b2 = c.c0; q.cnt = 3'd4;
      end
      DST_RGB565: begin
        w = {c.c0[7:3], c.c1[7:2], c.c2[7:3]};
        q.b0 = w[15:8]; q.b1 = w[7:0]; q.cnt = 3'd2;
      end
      DST_RGB555: begin
        w = {1'b0, c.c0[7:3], c.c1[7:3], c.c2[7:3]};
        q.b0 = w[15:8]; q.b1 = w[7:0]; q.cnt = 3'd2;
      end
      default: q.uns = 1'b1;
    endcase
    return q;
  endfunction

  // configuration
  logic [1:0] src_r;
  logic [2:0] dst_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SRC_RESET;
      dst_r <= DST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SOURCE_FORMAT) begin
        src_r <= cfg_data[1:0];
      end else if (cfg_index == CFG_DEST_FORMAT) begin
        dst_r <= cfg_data;
      end
    end
  end

  // pipeline control
  logic adv, acc;
  logic out_vld_r;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // palette
  pal_wr_t pal_wr;
  pix_t    pal_rgb;

  assign pal_wr.en  = acc && (in_operation == OP_PAL_WRITE);
  assign pal_wr.idx = in_entry_index;
  assign pal_wr.rgb = '{c0: in_byte0, c1: in_byte1, c2: in_byte2};

  pfc_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .rd_en  (adv),
    .rd_addr(in_byte0),
    .wr     (pal_wr),
    .rd_rgb (pal_rgb)
  );

  // stage 1: palette data available
  logic s1_vld_r, s1_last_r;
  pix_t s1_pix_r, s1_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc && (in_operation == OP_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r  <= '{c0: in_byte0, c1: in_byte1, c2: in_byte2};
      s1_last_r <= in_last_pixel;
    end
  end

  assign s1_col = (src_r == SRC_PAL) ? pal_rgb : s1_pix_r;

  // stage 2: products registered
  logic s2_vld_r, s2_last_r;
  pix_t s2_col_r, yuv_res, rgb_res;

  pfc_math u_math (
    .clk(clk),
    .en (adv),
    .col(s1_col),
    .yuv(yuv_res),
    .rgb(rgb_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col_r  <= s1_col;
      s2_last_r <= s1_last_r;
    end
  end

  // format selection
  res_t res_nxt;

  always_comb begin
    res_nxt = '0;
    unique case (src_r)
      SRC_GRAY: begin
        if (dst_r == DST_GRAY) begin
          res_nxt.b0 = s2_col_r.c0; res_nxt.cnt = 3'd1;
        end else if (dst_r == DST_YUV) begin
          res_nxt.b0 = s2_col_r.c0; res_nxt.cnt = 3'd3;
        end else begin
          res_nxt.uns = 1'b1;
        end
      end
      SRC_YUV: begin
        if (dst_r == DST_GRAY) begin
          res_nxt.b0 = s2_col_r.c0; res_nxt.cnt = 3'd1;
        end else if (dst_r == DST_YUV) begin
          res_nxt.b0 = s2_col_r.c0; res_nxt.b1 = s2_col_r.c1;
          res_nxt.b2 = s2_col_r.c2; res_nxt.cnt = 3'd3;
        end else begin
          res_nxt = put_rgb(dst_r, rgb_res);
        end
      end
      SRC_RGB: begin
        if (dst_r == DST_YUV) begin
          res_nxt.b0 = yuv_res.c0; res_nxt.b1 = yuv_res.c1;
          res_nxt.b2 = yuv_res.c2; res_nxt.cnt = 3'd3;
        end else if (dst_r == DST_RGB || dst_r == DST_RGB565 || dst_r == DST_RGB555) begin
          res_nxt = put_rgb(dst_r, s2_col_r);
        end else begin
          res_nxt.uns = 1'b1;
        end
      end
      SRC_PAL: begin
        if (dst_r == DST_GRAY) begin
          res_nxt.b0 = yuv_res.c0; res_nxt.cnt = 3'd1;
        end else if (dst_r == DST_YUV) begin
          res_nxt.b0 = yuv_res.c0; res_nxt.b1 = yuv_res.c1;
          res_nxt.b2 = yuv_res.c2; res_nxt.cnt = 3'd3;
        end else begin
          res_nxt = put_rgb(dst_r, s2_col_r);
        end
      end
      default: res_nxt.uns = 1'b1;
    endcase
  end

  // stage 3: output register
  res_t res_r;
  logic last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      last_r <= s2_last_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_byte0       = res_r.b0;
  assign out_byte1       = res_r.b1;
  assign out_byte2       = res_r.b2;
  assign out_byte3       = res_r.b3;
  assign out_byte_count  = res_r.cnt;
  assign out_unsupported = res_r.uns;
  assign out_last_out    = last_r;

`ifndef SYNTHESIS
  a_unsup_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_unsupported |->
      out_byte_count == 3'd0 && out_byte0 == 8'd0 && out_byte1 == 8'd0 &&
      out_byte2 == 8'd0)
    else $error("unsupported result carries data");

  a_bgrx_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_byte_count == 3'd4 |-> dst_r == DST_BGRX)
    else $error("four-byte result outside BGRX");

  a_pal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_operation == OP_PAL_WRITE |=> !s1_vld_r)
    else $error("palette write entered the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_vld_r) && $stable(s2_vld_r) && $stable(res_r))
    else $error("pipeline moved while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_byte_count <= 3'd4 && out_byte3 == 8'd0)
    else $error("byte count or padding out of range");
`endif

endmodule

`default_nettype wire
